FILE: hw/rtl/pqd_pkg.sv
// ----------------------------------------------------------------------------
// pqd_pkg
// Shared types, constants and the single-precision adder for the PQ distance
// block.
// ----------------------------------------------------------------------------
package pqd_pkg;

  localparam int unsigned TableRow  = 256;
  localparam int unsigned FifoDepth = 4;

  localparam logic [6:0]  CountReset = 7'd8;

  // configuration register indexes
  localparam logic CfgSubqCount    = 1'b0;
  localparam logic CfgBaseDistance = 1'b1;

  // item kinds on tuser
  localparam logic OpTableWrite = 1'b0;
  localparam logic OpCode       = 1'b1;

  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;

  // one lookup result handed from front to back
  typedef struct packed {
    logic [31:0] term;
    logic [31:0] base;
    logic        first;
    logic        close;
    logic        bend;
  } pqd_entry_t;

  // IEEE single addition, round to nearest even
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y;
    logic        sx, sy, sr;
    logic [7:0]  ex, ey;
    logic [8:0]  e;
    logic [7:0]  d;
    logic [26:0] mx, my, mys;
    logic [27:0] s;
    logic [23:0] m;
    logic [24:0] mr;
    logic [4:0]  lz;
    logic [8:0]  sh;
    logic        found, g, rs, up;
    logic [31:0] res;
    res = 32'h0;
    // NaN and infinity
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      if (a[30:23] == 8'hFF && a[22:0] != 23'h0) begin
        res = a | 32'h0040_0000;
      end else if (b[30:23] == 8'hFF && b[22:0] != 23'h0) begin
        res = b | 32'h0040_0000;
      end else if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) begin
        res = DefaultNan;
      end else if (a[30:23] == 8'hFF) begin
        res = a;
      end else begin
        res = b;
      end
      return res;
    end
    // order by magnitude
    if (a[30:0] >= b[30:0]) begin
      x = a; y = b;
    end else begin
      x = b; y = a;
    end
    sx = x[31]; sy = y[31];
    ex = (x[30:23] == 8'h0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'h0) ? 8'd1 : y[30:23];
    mx = {(x[30:23] != 8'h0), x[22:0], 3'b000};
    my = {(y[30:23] != 8'h0), y[22:0], 3'b000};
    d  = ex - ey;
    // align with sticky
    if (d >= 8'd27) begin
      mys = {26'h0, (my != 27'h0)};
    end else begin
      mys = my >> d;
      if ((my & ((27'h1 << d) - 27'h1)) != 27'h0) mys[0] = 1'b1;
    end
    if (sx == sy) s = {1'b0, mx} + {1'b0, mys};
    else          s = {1'b0, mx} - {1'b0, mys};
    if (s == 28'h0) begin
      res = (sx == sy) ? {sx, 31'h0} : 32'h0;
      return res;
    end
    sr = sx;
    e  = {1'b0, ex};
    if (s[27]) begin
      s = {1'b0, s[27:2], s[1] | s[0]};
      e = e + 9'd1;
    end else begin
      // leading zero count over the 27-bit sum
      lz = 5'd0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
        if (!found && s[i]) begin
          found = 1'b1;
          lz = 5'(26 - i);
        end
      end
      sh = ({4'h0, lz} < e - 9'd1) ? {4'h0, lz} : e - 9'd1;
      s  = s << sh;
      e  = e - sh;
    end
    m  = s[26:3];
    g  = s[2];
    rs = s[1] | s[0];
    up = g & (rs | m[0]);
    mr = {1'b0, m} + {24'h0, up};
    if (mr[24]) begin
      mr = mr >> 1;
      e  = e + 9'd1;
    end
    if (e >= 9'd255) begin
      res = {sr, 8'hFF, 23'h0};
    end else begin
      res = {sr, (mr[23] ? e[7:0] : 8'h0), mr[22:0]};
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/pqd_fifo.sv
// ----------------------------------------------------------------------------
// pqd_fifo
// Short queue of lookup results between front and back.
// ----------------------------------------------------------------------------
module pqd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pqd_pkg::pqd_entry_t push_data_i,
  input  logic               pop_i,
  output pqd_pkg::pqd_entry_t pop_data_o,
  output logic               empty_o,
  output logic [2:0]         count_o
);
  import pqd_pkg::*;

  pqd_entry_t entry_q [FifoDepth];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end

  // store entries
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  assign pop_data_o = entry_q[rd_ptr_q];
  assign empty_o    = (count_q == 3'd0);
  assign count_o    = count_q;

endmodule

FILE: hw/rtl/pqd_front.sv
// ----------------------------------------------------------------------------
// pqd_front
// Accepts items, writes table entries, tracks the subquantizer position and
// reads the table for each code byte.
// ----------------------------------------------------------------------------
module pqd_front #(
  parameter int unsigned MaxSubq = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               op_i,
  input  logic [5:0]         sub_index_i,
  input  logic [7:0]         code_byte_i,
  input  logic [31:0]        table_value_i,
  input  logic               batch_end_i,
  input  logic [6:0]         subq_count_i,
  input  logic [31:0]        base_distance_i,
  input  logic [2:0]         fifo_count_i,
  output logic               push_o,
  output pqd_pkg::pqd_entry_t push_data_o
);
  import pqd_pkg::*;

  localparam int unsigned SubqW  = (MaxSubq > 1) ? $clog2(MaxSubq) : 1;
  localparam int unsigned AddrW  = SubqW + 8;
  localparam int unsigned Depth  = MaxSubq * TableRow;

  logic [31:0]      mem_q [Depth];
  logic [31:0]      rdata_q;
  logic [SubqW-1:0] pos_q;
  logic             rd_vld_q;
  logic             first_q, close_q, bend_q;
  logic [31:0]      base_q;

  logic             accept, wr_en, rd_en, close;
  logic [8:0]       sub9, pos9, eff;
  logic [AddrW-1:0] wr_addr, rd_addr;

  // room for this item once the one in flight lands
  assign ready_o = ({1'b0, fifo_count_i} + {3'b0, rd_vld_q}) < 4'(FifoDepth);
  assign accept  = valid_i && ready_o;

  // clamp the count into one..MaxSubq
  always_comb begin
    if (subq_count_i == 7'd0)                  eff = 9'd1;
    else if ({2'b0, subq_count_i} > 9'(MaxSubq)) eff = 9'(MaxSubq);
    else                                       eff = {2'b0, subq_count_i};
  end

  assign sub9    = {3'b0, sub_index_i};
  assign pos9    = 9'(pos_q);
  assign wr_en   = accept && (op_i == OpTableWrite) && (sub9 < 9'(MaxSubq));
  assign rd_en   = accept && (op_i == OpCode);
  assign close   = (pos9 + 9'd1) >= eff;
  assign wr_addr = {sub9[SubqW-1:0], code_byte_i};
  assign rd_addr = {pos_q, code_byte_i};

  // table memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= table_value_i;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  // position and read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (rd_en) pos_q <= close ? '0 : pos_q + 1'b1;
    end
  end

  // tag travels beside the read
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      first_q <= (pos_q == '0);
      close_q <= close;
      bend_q  <= batch_end_i;
      base_q  <= base_distance_i;
    end
  end

  assign push_o            = rd_vld_q;
  assign push_data_o.term  = rdata_q;
  assign push_data_o.base  = base_q;
  assign push_data_o.first = first_q;
  assign push_data_o.close = close_q;
  assign push_data_o.bend  = bend_q;

endmodule

FILE: hw/rtl/pqd_back.sv
// ----------------------------------------------------------------------------
// pqd_back
// Accumulates lookup terms in single precision and holds each distance in
// an output register until taken.
// ----------------------------------------------------------------------------
module pqd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  pqd_pkg::pqd_entry_t entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         distance_o,
  output logic                batch_last_o
);
  import pqd_pkg::*;

  logic [31:0] sum_q, sum_d;
  logic [31:0] dist_q;
  logic        last_q, out_vld_q;
  logic        out_free;

  assign out_free = !out_vld_q || out_ready_i;
  assign pop_o    = !empty_i && (!entry_i.close || out_free);
  assign sum_d    = fp_add(entry_i.first ? entry_i.base : sum_q, entry_i.term);

  // accumulate and present the distance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_ready_i) out_vld_q <= 1'b0;
      if (pop_o) begin
        sum_q <= sum_d;
        if (entry_i.close) out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.close) begin
      dist_q <= sum_d;
      last_q <= entry_i.bend;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign distance_o   = dist_q;
  assign batch_last_o = last_q;

endmodule

FILE: hw/rtl/pq_table_distance_8bit.sv
// A code byte closing a vector reaches the output through the table read register,
// the queue and the output register. Throughput: one item per cycle while the queue
// has room and the output is taken; table read and back-part float add set that rate.
// Reset: asynchronous, active low; clears position, sum, queue and output valid;
// the table is not cleared and holds nothing defined until written.
// ----------------------------------------------------------------------------
// pq_table_distance_8bit
// Product-quantization distance by table lookup over 8-bit codes.
// ----------------------------------------------------------------------------
module pq_table_distance_8bit #(
  parameter int unsigned MaxSubq = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sub_index[5:0], code_byte[13:6], table_value[45:14]
  input  logic        s_axis_tuser,   // op
  input  logic        s_axis_tlast,   // batch_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // distance[31:0]
  output logic        m_axis_tlast,   // batch_last
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import pqd_pkg::*;

  logic [6:0]  subq_count_q;
  logic [31:0] base_q;
  logic        push, pop, empty;
  logic [2:0]  fifo_count;
  pqd_entry_t  push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subq_count_q <= CountReset;
      base_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSubqCount:    subq_count_q <= cfg_wdata_i[6:0];
        CfgBaseDistance: base_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pqd_front #(.MaxSubq(MaxSubq)) u_front (
    .clk_i, .rst_ni,
    .valid_i         (s_axis_tvalid),
    .ready_o         (s_axis_tready),
    .op_i            (s_axis_tuser),
    .sub_index_i     (s_axis_tdata[5:0]),
    .code_byte_i     (s_axis_tdata[13:6]),
    .table_value_i   (s_axis_tdata[45:14]),
    .batch_end_i     (s_axis_tlast),
    .subq_count_i    (subq_count_q),
    .base_distance_i (base_q),
    .fifo_count_i    (fifo_count),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  pqd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty),
    .count_o     (fifo_count)
  );

  pqd_back u_back (
    .clk_i, .rst_ni,
    .empty_i      (empty),
    .entry_i      (pop_data),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .distance_o   (m_axis_tdata),
    .batch_last_o (m_axis_tlast)
  );

endmodule

FILE: hw/rtl/pqd_checker.sv
// ----------------------------------------------------------------------------
// pqd_checker
// Port-level checks for the PQ distance block, bound to the top level.
// ----------------------------------------------------------------------------
module pqd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // hold a stalled distance
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled distance changed");

  // no distance while in reset
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // a distance never appears in the first cycle after reset release
  a_no_early: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("distance without any accepted item");

  // a new distance must not rise while $past(rst_ni, 2) still shows reset asserted
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && !$past(rst_ni, 2) |-> 1'b0)
    else $error("distance too soon after reset");

endmodule

bind pq_table_distance_8bit pqd_checker u_pqd_checker (
  .clk_i, .rst_ni,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
